>>> hdl/crc16rb_pkg.sv
// ----------------------------------------------------------------------------
// crc16rb_pkg : shared constants and helpers for the reflected CRC-16 stream
// Holds the polynomial, the register seed and the byte fold function.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16rb_pkg;

   localparam int unsigned CrcWidth  = 16;
   localparam int unsigned ByteWidth = 8;

   // Reflected X.25 polynomial and register seed
   localparam logic [CrcWidth-1:0] CRC_POLY = 16'h8408;
   localparam logic [CrcWidth-1:0] CRC_INIT = 16'hFFFF;

   // Fold one byte into the register, least significant bit first
   function automatic logic [CrcWidth-1:0] crc_fold_byte(
      input logic [CrcWidth-1:0]  crc,
      input logic [ByteWidth-1:0] data
   );
      logic [CrcWidth-1:0] r;
      r = crc;
      for (int k = 0; k < ByteWidth; k++) begin
         if (r[0] ^ data[k]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // Final value: inverted register with its two bytes swapped
   function automatic logic [CrcWidth-1:0] crc_finish(input logic [CrcWidth-1:0] crc);
      logic [CrcWidth-1:0] inv;
      inv = ~crc;
      return {inv[7:0], inv[15:8]};
   endfunction

endpackage

`default_nettype wire

>>> hdl/crc16_reflected_byte_stream.sv
// ----------------------------------------------------------------------------
// crc16_reflected_byte_stream : reflected CRC-16 (X.25) over a byte stream
//
// Usage
//   req channel : one message byte per word in req_tdata, req_tlast high on
//                 the final byte of each message. Every message holds at
//                 least one byte.
//   rsp channel : one 16-bit checksum word per message, given after its last
//                 byte: inverted CRC with high and low bytes swapped.
//   Throughput  : one byte per cycle outside the stall below; the eight-step
//                 fold sits between the input register and the CRC register.
//   Path        : a last byte goes from the input register into the output
//                 register, from which its checksum word is taken.
//   Reset       : synchronous; the CRC register returns to 0xFFFF and both
//                 the input and the output register are emptied.
//   Stalls      : the output register holds its word until rsp_tready; while
//                 it is full and rsp_tready is low, bytes not marked last flow through, a
//                 last byte waits in the input register and req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_reflected_byte_stream
   import crc16rb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Input words
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteWidth-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic                 req_tlast,  // last_byte
   // Result words
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [CrcWidth-1:0]       rsp_tdata   // [15:0] checksum
);

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;

   // Running CRC and output register
   logic [CrcWidth-1:0]  crc_ff, crc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CrcWidth-1:0]  rsp_data_ff, rsp_data_in;

   logic                 fold_go;
   logic                 req_take;
   logic [CrcWidth-1:0]  crc_next;

   // Fold stage may proceed unless a last byte meets a full, stalled output
   assign fold_go    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fold_go;
   assign req_take   = req_tvalid && req_tready;

   assign crc_next   = crc_fold_byte(crc_ff, in_byte_ff);

   // Next-state logic
   always_comb begin
      in_valid_in  = in_valid_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (fold_go) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            crc_in       = CRC_INIT;
            rsp_valid_in = 1'b1;
            rsp_data_in  = crc_finish(crc_next);
         end else begin
            crc_in = crc_next;
         end
      end

      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // Reset seeds the CRC and empties the output
   a_reset_seed : assert property (@(posedge clock)
      reset |=> (crc_ff == CRC_INIT && !rsp_valid_ff))
      else $error("CRC not seeded after reset");

   // Folding a last byte reseeds the CRC and loads a result
   a_last_reseed : assert property (@(posedge clock) disable iff (reset)
      (fold_go && in_last_ff) |=> (crc_ff == CRC_INIT && rsp_valid_ff))
      else $error("last byte did not produce a result");

   // A result only appears after a last byte was folded
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fold_go && in_last_ff))
      else $error("result word without a last byte");

   // A stalled byte in the input register is kept
   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fold_go) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_last_ff)))
      else $error("stalled input byte lost");

endmodule

`default_nettype wire
